// ===== design/swrm_pkg.sv =====
// Shared types and constants for the sliding window rate meter.
`default_nettype none

package swrm_pkg;

  localparam int TIME_W       = 32;
  localparam int BYTES_W      = 31;
  localparam int SLOT_BYTES_W = 32;
  localparam int TOTAL_W      = 40;
  localparam int GRAND_W      = 48;
  localparam int AVG_W        = 32;
  localparam int DIVISOR_W    = TIME_W + 1;
  localparam int DIFF_W       = TIME_W + 2;
  localparam int DIV_CNT_W    = $clog2(TOTAL_W);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic FUNC_RECORD  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [AVG_W-1:0]   AVG_MAX     = 32'h7FFF_FFFF;
  localparam logic [AVG_W-1:0]   AVG_MIN     = 32'h8000_0000;
  localparam logic [TOTAL_W-1:0] AVG_MAX_EXT = 40'h00_7FFF_FFFF;
  localparam logic [TOTAL_W-1:0] AVG_MIN_MAG = 40'h00_8000_0000;

  typedef struct packed {
    logic               func;
    logic [TIME_W-1:0]  now_sec;
    logic [BYTES_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg_speed;
    logic [BYTES_W-1:0]      momentary_speed;
    logic [GRAND_W-1:0]      grand_total;
  } out_item_t;

  typedef struct packed {
    logic               func;
    logic [TIME_W-1:0]  now_sec;
    logic [BYTES_W-1:0] byte_count;
    logic [TIME_W-1:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]       slot_time;
  } slot_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_SEND
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_LOOKUP2,
    B_ADVANCE,
    B_UPDATE,
    B_RESTART,
    B_DIV_START,
    B_DIV_WAIT,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/swrm_front.sv =====
// Front part: accepts items and works out the time slot of each one.
`default_nettype none

module swrm_front #(
  parameter int SLOT_SECONDS = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire swrm_pkg::in_item_t item,
  output logic                  q_push,
  input  wire logic             q_full,
  output swrm_pkg::cmd_t        q_data
);

  // The slot is the product with a rounded-up reciprocal, exact for every 32-bit time.
  localparam int SHIFT  = swrm_pkg::TIME_W + $clog2(SLOT_SECONDS);
  localparam int PROD_W = SHIFT + swrm_pkg::TIME_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(SLOT_SECONDS) - 64'd1) / 64'(SLOT_SECONDS);
  localparam logic [PROD_W-1:0] RECIP_EXT = PROD_W'(RECIP);

  swrm_pkg::front_state_t state, state_next;
  swrm_pkg::in_item_t     hold;
  logic [swrm_pkg::TIME_W-1:0] quo;
  logic [PROD_W-1:0]           prod;

  assign prod = {{(PROD_W - swrm_pkg::TIME_W){1'b0}}, hold.now_sec} * RECIP_EXT;

  always_comb begin
    state_next = state;
    case (state)
      swrm_pkg::F_IDLE: if (push) state_next = swrm_pkg::F_DIV;
      swrm_pkg::F_DIV:  state_next = swrm_pkg::F_SEND;
      swrm_pkg::F_SEND: if (!q_full) state_next = swrm_pkg::F_IDLE;
      default: state_next = swrm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != swrm_pkg::F_IDLE);
    q_push = (state == swrm_pkg::F_SEND);
  end

  assign q_data.func       = hold.func;
  assign q_data.now_sec    = hold.now_sec;
  assign q_data.byte_count = hold.byte_count;
  assign q_data.slot       = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrm_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      swrm_pkg::F_IDLE: begin
        hold <= item;
      end
      swrm_pkg::F_DIV: begin
        quo <= prod[SHIFT +: swrm_pkg::TIME_W];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/swrm_queue.sv =====
// Short queue of classified items between the front and back parts.
`default_nettype none

module swrm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire swrm_pkg::cmd_t wr_data,
  input  wire logic           pop,
  output logic                empty,
  output swrm_pkg::cmd_t      rd_data
);

  swrm_pkg::cmd_t entries [swrm_pkg::QUEUE_DEPTH];
  logic [swrm_pkg::QPTR_W-1:0] wr_ptr;
  logic [swrm_pkg::QPTR_W-1:0] rd_ptr;
  logic [swrm_pkg::QPTR_W:0]   count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == (swrm_pkg::QPTR_W + 1)'(swrm_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == swrm_pkg::QPTR_W'(swrm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == swrm_pkg::QPTR_W'(swrm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/swrm_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module swrm_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [swrm_pkg::TOTAL_W-1:0]   dividend,
  input  wire logic [swrm_pkg::DIVISOR_W-1:0] divisor,
  output logic                                done,
  output logic [swrm_pkg::TOTAL_W-1:0]        quotient
);

  logic                                busy;
  logic [swrm_pkg::DIV_CNT_W-1:0]      cnt;
  logic [swrm_pkg::DIVISOR_W-1:0]      dvs;
  logic [swrm_pkg::DIVISOR_W-1:0]      rem;
  logic [swrm_pkg::DIVISOR_W:0]        trial;
  logic                                ge;

  assign trial = {rem, quotient[swrm_pkg::TOTAL_W-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == swrm_pkg::DIV_CNT_W'(swrm_pkg::TOTAL_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      cnt      <= '0;
    end else if (busy) begin
      quotient <= {quotient[swrm_pkg::TOTAL_W-2:0], ge};
      rem      <= ge ? swrm_pkg::DIVISOR_W'(trial - {1'b0, dvs})
                     : swrm_pkg::DIVISOR_W'(trial);
      cnt      <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/swrm_back.sv =====
// Back part: slot ring, window totals, speed division and the result register.
`default_nettype none

module swrm_back #(
  parameter int SLOT_COUNT   = 32,
  parameter int SLOT_SECONDS = 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire swrm_pkg::cmd_t q_data,
  output logic                empty,
  input  wire logic           pop,
  output swrm_pkg::out_item_t result
);

  localparam int IW   = $clog2(SLOT_COUNT);
  localparam int SS_W = $clog2(SLOT_SECONDS + 1);
  localparam int SC_W = swrm_pkg::TIME_W + SS_W;

  swrm_pkg::back_state_t state, state_next;
  swrm_pkg::cmd_t        cmd;
  swrm_pkg::slot_entry_t mem [SLOT_COUNT];
  swrm_pkg::slot_entry_t rdata;
  swrm_pkg::slot_entry_t wdata;
  logic                  rd_valid;
  logic [SLOT_COUNT-1:0] valid;
  logic [IW-1:0]         idx;
  logic [swrm_pkg::TIME_W-1:0]       fill_time;
  logic [swrm_pkg::SLOT_BYTES_W-1:0] cur_bytes;
  logic [swrm_pkg::TIME_W-1:0]       cur_time;
  logic [swrm_pkg::SLOT_BYTES_W-1:0] sb;
  logic [swrm_pkg::TIME_W-1:0]       st;
  logic [swrm_pkg::TOTAL_W-1:0]      total;
  logic [swrm_pkg::TIME_W-1:0]       start_slot;
  logic [swrm_pkg::TIME_W-1:0]       stamp;
  logic [swrm_pkg::BYTES_W-1:0]      sec_bytes;
  logic [swrm_pkg::GRAND_W-1:0]      all_bytes;
  logic [swrm_pkg::SLOT_BYTES_W-1:0] room;
  logic [swrm_pkg::SLOT_BYTES_W-1:0] bytes_ext;
  logic [swrm_pkg::SLOT_BYTES_W-1:0] taken;
  logic [swrm_pkg::BYTES_W-1:0]      sec_base;
  logic [swrm_pkg::BYTES_W:0]        sec_sum;
  logic [SC_W-1:0]                   scaled;
  logic [swrm_pkg::DIFF_W-1:0]       diff;
  logic [swrm_pkg::DIFF_W-1:0]       diff_mag;
  logic                              diff_zero;
  logic                              diff_neg;
  logic                              div_start;
  logic                              div_done;
  logic [swrm_pkg::TOTAL_W-1:0]      quo;
  logic [swrm_pkg::AVG_W-1:0]        avg;
  logic                              mem_we;
  logic                              load;
  logic                              res_valid;

  assign cur_bytes = rd_valid ? rdata.bytes : '0;
  assign cur_time  = rd_valid ? rdata.slot_time : fill_time;

  assign room      = ~sb;
  assign bytes_ext = {1'b0, cmd.byte_count};
  assign taken     = (bytes_ext < room) ? bytes_ext : room;
  assign wdata.bytes     = sb + taken;
  assign wdata.slot_time = st;

  assign sec_base = (cmd.now_sec != stamp) ? '0 : sec_bytes;
  assign sec_sum  = {1'b0, sec_base} + {1'b0, cmd.byte_count};

  assign scaled   = {{SS_W{1'b0}}, start_slot} * {{swrm_pkg::TIME_W{1'b0}}, SS_W'(SLOT_SECONDS)};
  assign diff     = {2'b00, cmd.now_sec} - {1'b0, scaled[swrm_pkg::TIME_W:0]};
  assign diff_mag = diff[swrm_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;

  swrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total),
    .divisor  (diff_mag[swrm_pkg::DIVISOR_W-1:0]),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    if (diff_zero) begin
      avg = '0;
    end else if (diff_neg) begin
      avg = (quo > swrm_pkg::AVG_MIN_MAG) ? swrm_pkg::AVG_MIN
                                          : (~quo[swrm_pkg::AVG_W-1:0] + 1'b1);
    end else begin
      avg = (quo > swrm_pkg::AVG_MAX_EXT) ? swrm_pkg::AVG_MAX : quo[swrm_pkg::AVG_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swrm_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_data.func == swrm_pkg::FUNC_RESTART) ? swrm_pkg::B_RESTART
                                                               : swrm_pkg::B_CHECK;
        end
      end
      swrm_pkg::B_CHECK: begin
        state_next = (cmd.slot > cur_time) ? swrm_pkg::B_LOOKUP2 : swrm_pkg::B_UPDATE;
      end
      swrm_pkg::B_LOOKUP2:   state_next = swrm_pkg::B_ADVANCE;
      swrm_pkg::B_ADVANCE:   state_next = swrm_pkg::B_UPDATE;
      swrm_pkg::B_UPDATE:    state_next = swrm_pkg::B_DIV_START;
      swrm_pkg::B_RESTART:   state_next = swrm_pkg::B_DIV_START;
      swrm_pkg::B_DIV_START: state_next = swrm_pkg::B_DIV_WAIT;
      swrm_pkg::B_DIV_WAIT:  if (div_done) state_next = swrm_pkg::B_EMIT;
      swrm_pkg::B_EMIT:      if (!res_valid || pop) state_next = swrm_pkg::B_IDLE;
      default:               state_next = swrm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == swrm_pkg::B_IDLE) && !q_empty;
    mem_we    = (state == swrm_pkg::B_UPDATE);
    div_start = (state == swrm_pkg::B_DIV_START);
    load      = (state == swrm_pkg::B_EMIT) && (!res_valid || pop);
    empty     = !res_valid;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= wdata;
    end
    rdata    <= mem[idx];
    rd_valid <= valid[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= swrm_pkg::B_IDLE;
      valid      <= '0;
      idx        <= '0;
      fill_time  <= '0;
      total      <= '0;
      start_slot <= '0;
      stamp      <= '0;
      sec_bytes  <= '0;
      all_bytes  <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        swrm_pkg::B_CHECK: begin
          if (cmd.slot > cur_time) begin
            idx <= (idx == IW'(SLOT_COUNT - 1)) ? '0 : idx + 1'b1;
          end
        end
        swrm_pkg::B_ADVANCE: begin
          total      <= total - {{(swrm_pkg::TOTAL_W - swrm_pkg::SLOT_BYTES_W){1'b0}}, cur_bytes};
          start_slot <= cur_time;
        end
        swrm_pkg::B_UPDATE: begin
          if (total == '0) begin
            start_slot <= cmd.slot;
          end
          total      <= total + {{(swrm_pkg::TOTAL_W - swrm_pkg::SLOT_BYTES_W){1'b0}}, taken};
          valid[idx] <= 1'b1;
          stamp      <= cmd.now_sec;
          sec_bytes  <= sec_sum[swrm_pkg::BYTES_W] ? '1 : sec_sum[swrm_pkg::BYTES_W-1:0];
          all_bytes  <= all_bytes
                      + {{(swrm_pkg::GRAND_W - swrm_pkg::BYTES_W){1'b0}}, cmd.byte_count};
        end
        swrm_pkg::B_RESTART: begin
          valid      <= '0;
          fill_time  <= cmd.slot;
          idx        <= '0;
          total      <= '0;
          start_slot <= cmd.slot;
          stamp      <= '0;
          sec_bytes  <= '0;
        end
        default: begin
        end
      endcase
      if (load) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    case (state)
      swrm_pkg::B_CHECK: begin
        sb <= cur_bytes;
        st <= cur_time;
      end
      swrm_pkg::B_ADVANCE: begin
        sb <= '0;
        st <= cmd.slot;
      end
      swrm_pkg::B_DIV_START: begin
        diff_zero <= (diff == '0);
        diff_neg  <= diff[swrm_pkg::DIFF_W-1];
      end
      default: begin
      end
    endcase
    if (load) begin
      result.avg_speed       <= avg;
      result.momentary_speed <= (cmd.now_sec == stamp) ? sec_bytes : '0;
      result.grand_total     <= all_bytes;
    end
  end

endmodule

`default_nettype wire

// ===== design/sliding_window_rate_meter.sv =====
// Top level of the sliding window rate meter.
`default_nettype none

// Each item either records a byte reading at a time in seconds or restarts the
// speed window, and each item yields one result with the average speed over the
// window, the bytes in the current second and the grand byte total. The front
// part works out the time slot with a multiplication by the reciprocal of
// SLOT_SECONDS and takes no new item until the last one is in the queue; a
// two-entry queue lets it run ahead of the back part. In the back part the
// 40-step speed divider sets most of the time per item; a reading takes longer
// than a restart, and longer still when the ring advances. The slot ring
// is a memory with a valid bit per slot, so a restart or reset clears it at once
// and there is no clearing pass. The result register lets the next item be
// taken while a finished result waits for pop.
module sliding_window_rate_meter #(
  parameter int SLOT_COUNT   = 32,
  parameter int SLOT_SECONDS = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire swrm_pkg::in_item_t item,
  output logic                    empty,
  input  wire logic               pop,
  output swrm_pkg::out_item_t     result
);

  logic           fq_push;
  logic           fq_full;
  swrm_pkg::cmd_t fq_data;
  logic           bq_pop;
  logic           bq_empty;
  swrm_pkg::cmd_t bq_data;

  swrm_front #(
    .SLOT_SECONDS (SLOT_SECONDS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_data (fq_data)
  );

  swrm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fq_push),
    .full    (fq_full),
    .wr_data (fq_data),
    .pop     (bq_pop),
    .empty   (bq_empty),
    .rd_data (bq_data)
  );

  swrm_back #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SLOT_SECONDS (SLOT_SECONDS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (bq_empty),
    .q_pop   (bq_pop),
    .q_data  (bq_data),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire
